[src/rpt_pkg.sv]
// Shared types, register codes and saturation helpers for the rigid point transform.
package rpt_pkg;

  localparam int unsigned FRAC_W = 30;

  typedef logic signed [31:0] fix_t;

  typedef enum logic [2:0] {
    CFG_QX,
    CFG_QY,
    CFG_QZ,
    CFG_QW,
    CFG_TX,
    CFG_TY,
    CFG_TZ,
    CFG_INV
  } cfg_idx_e;

  localparam fix_t QW_RESET = 32'sh4000_0000;

  typedef struct packed {
    fix_t point_x;
    fix_t point_y;
    fix_t point_z;
  } point_t;

  typedef struct packed {
    fix_t out_x;
    fix_t out_y;
    fix_t out_z;
    logic overflow;
  } result_t;

  // Row-major rotation matrix, element 3*row+col.
  typedef logic [8:0][31:0] mat_t;

  typedef struct packed {
    logic valid;
    logic ovf;
    fix_t x;
    fix_t y;
    fix_t z;
  } vec_beat_t;

  function automatic logic ovf32(input logic signed [39:0] v);
    return (v > 40'sh00_7FFF_FFFF) || (v < -40'sh00_8000_0000);
  endfunction

  function automatic fix_t sat32(input logic signed [39:0] v);
    fix_t r;
    if (v > 40'sh00_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sh00_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/rigid_point_transform.sv]
// Top level of the rigid point transform: configuration registers, pipeline and checks.
//
//  port group       | dir | timing
//  start_i/point_i  | in  | beat taken when start_i && !busy_o
//  busy_o           | out | always low, a beat may enter every cycle
//  result_valid_o   | out | one-cycle strobe per result beat, no back-pressure
//  cfg_we_i/idx/data| in  | register written at the edge with cfg_we_i high
//
// One point per clock. A point passes through these registered stages in order:
// input/difference stage, delay stage, nine 32x32 products, three-term rounded
// sum, translation add and saturation. The matrix is rebuilt every cycle from the
// registers in two stages that run alongside the first two point stages. Reset
// clears the valid bits and loads the identity transform; nothing can stall the
// pipe.
module rigid_point_transform
  import rpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  point_t      point_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  fix_t      qx_q, qy_q, qz_q, qw_q, tx_q, ty_q, tz_q;
  logic      inv_q;
  mat_t      mat;
  vec_beat_t front_beat;
  logic      accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q  <= '0;
      qy_q  <= '0;
      qz_q  <= '0;
      qw_q  <= QW_RESET;
      tx_q  <= '0;
      ty_q  <= '0;
      tz_q  <= '0;
      inv_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_QX:  qx_q  <= cfg_data_i;
        CFG_QY:  qy_q  <= cfg_data_i;
        CFG_QZ:  qz_q  <= cfg_data_i;
        CFG_QW:  qw_q  <= cfg_data_i;
        CFG_TX:  tx_q  <= cfg_data_i;
        CFG_TY:  ty_q  <= cfg_data_i;
        CFG_TZ:  tz_q  <= cfg_data_i;
        CFG_INV: inv_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rpt_matrix u_matrix (
    .clk_i (clk_i),
    .qx_i  (qx_q),
    .qy_i  (qy_q),
    .qz_i  (qz_q),
    .qw_i  (qw_q),
    .mat_o (mat)
  );

  rpt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .point_i   (point_i),
    .inverse_i (inv_q),
    .tx_i      (tx_q),
    .ty_i      (ty_q),
    .tz_i      (tz_q),
    .beat_o    (front_beat)
  );

  rpt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (front_beat),
    .mat_i     (mat),
    .inverse_i (inv_q),
    .tx_i      (tx_q),
    .ty_i      (ty_q),
    .tz_i      (tz_q),
    .valid_o   (result_valid_o),
    .result_o  (result_o)
  );

  // every result traces back to an earlier input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, 5))
    else $error("result strobe without matching input beat");

  // saturated difference must reach the overflow flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_beat.valid && front_beat.ovf) |-> ##3 (result_valid_o && result_o.overflow))
    else $error("difference saturation lost before output");

  // no result appears without a beat in the back pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(front_beat.valid, 3))
    else $error("result strobe without front stage beat");

endmodule

[src/rpt_matrix.sv]
// Rotation matrix from the quaternion registers: product stage, then coefficient stage.
module rpt_matrix
  import rpt_pkg::*;
(
  input  logic clk_i,
  input  fix_t qx_i,
  input  fix_t qy_i,
  input  fix_t qz_i,
  input  fix_t qw_i,
  output mat_t mat_o
);

  function automatic logic signed [33:0] qprod(input fix_t a, input fix_t b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return p[63:FRAC_W];
  endfunction

  function automatic fix_t coef(input logic signed [34:0] s, input logic diag);
    logic signed [39:0] v;
    v = (40'(s) <<< 1) + (diag ? 40'sh00_4000_0000 : 40'sd0);
    return sat32(v);
  endfunction

  logic signed [33:0] wx_q, wy_q, wz_q, xx_q, xy_q, xz_q, yy_q, yz_q, zz_q;
  mat_t mat_d, mat_q;

  always_ff @(posedge clk_i) begin
    wx_q <= qprod(qw_i, qx_i);
    wy_q <= qprod(qw_i, qy_i);
    wz_q <= qprod(qw_i, qz_i);
    xx_q <= qprod(qx_i, qx_i);
    xy_q <= qprod(qx_i, qy_i);
    xz_q <= qprod(qx_i, qz_i);
    yy_q <= qprod(qy_i, qy_i);
    yz_q <= qprod(qy_i, qz_i);
    zz_q <= qprod(qz_i, qz_i);
  end

  always_comb begin
    mat_d[0] = coef(-(35'(yy_q) + 35'(zz_q)), 1'b1);
    mat_d[1] = coef(35'(xy_q) - 35'(wz_q), 1'b0);
    mat_d[2] = coef(35'(wy_q) + 35'(xz_q), 1'b0);
    mat_d[3] = coef(35'(wz_q) + 35'(xy_q), 1'b0);
    mat_d[4] = coef(-(35'(xx_q) + 35'(zz_q)), 1'b1);
    mat_d[5] = coef(35'(yz_q) - 35'(wx_q), 1'b0);
    mat_d[6] = coef(35'(xz_q) - 35'(wy_q), 1'b0);
    mat_d[7] = coef(35'(wx_q) + 35'(yz_q), 1'b0);
    mat_d[8] = coef(-(35'(xx_q) + 35'(yy_q)), 1'b1);
  end

  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  assign mat_o = mat_q;

endmodule

[src/rpt_front.sv]
// Input stages: point capture and, in inverse mode, saturated subtraction of the translation.
module rpt_front
  import rpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  point_t    point_i,
  input  logic      inverse_i,
  input  fix_t      tx_i,
  input  fix_t      ty_i,
  input  fix_t      tz_i,
  output vec_beat_t beat_o
);

  logic signed [39:0] dx, dy, dz;
  vec_beat_t s1_d, s1_q, s2_q;

  always_comb begin
    dx = 40'(point_i.point_x) - 40'(tx_i);
    dy = 40'(point_i.point_y) - 40'(ty_i);
    dz = 40'(point_i.point_z) - 40'(tz_i);
    s1_d.valid = accept_i;
    if (inverse_i) begin
      s1_d.x   = sat32(dx);
      s1_d.y   = sat32(dy);
      s1_d.z   = sat32(dz);
      s1_d.ovf = ovf32(dx) | ovf32(dy) | ovf32(dz);
    end else begin
      s1_d.x   = point_i.point_x;
      s1_d.y   = point_i.point_y;
      s1_d.z   = point_i.point_z;
      s1_d.ovf = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  assign beat_o = s2_q;

endmodule

[src/rpt_back.sv]
// Back stages: matrix products, rounded row sums, forward translation add, saturation.
module rpt_back
  import rpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vec_beat_t beat_i,
  input  mat_t      mat_i,
  input  logic      inverse_i,
  input  fix_t      tx_i,
  input  fix_t      ty_i,
  input  fix_t      tz_i,
  output logic      valid_o,
  output result_t   result_o
);

  fix_t               pin [3];
  fix_t               tr  [3];
  logic signed [63:0] prod_d [9];
  logic signed [63:0] prod_q [9];
  logic signed [65:0] acc    [3];
  logic signed [35:0] sum_d  [3];
  logic signed [35:0] sum_q  [3];
  logic signed [39:0] fin    [3];
  logic               v3_q, v4_q, v5_q;
  logic               o3_q, o4_q;
  result_t            res_d, res_q;

  always_comb begin
    pin[0] = beat_i.x;
    pin[1] = beat_i.y;
    pin[2] = beat_i.z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (inverse_i) begin
          prod_d[3*r+c] = $signed(mat_i[3*c+r]) * pin[c];
        end else begin
          prod_d[3*r+c] = $signed(mat_i[3*r+c]) * pin[c];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(prod_q[3*r]) + 66'(prod_q[3*r+1]) + 66'(prod_q[3*r+2])
               + 66'sd536870912;
      sum_d[r] = acc[r][65:FRAC_W];
    end
  end

  always_comb begin
    tr[0] = tx_i;
    tr[1] = ty_i;
    tr[2] = tz_i;
    for (int r = 0; r < 3; r++) begin
      fin[r] = 40'(sum_q[r]) + (inverse_i ? 40'sd0 : 40'(tr[r]));
    end
    res_d.out_x    = sat32(fin[0]);
    res_d.out_y    = sat32(fin[1]);
    res_d.out_z    = sat32(fin[2]);
    res_d.overflow = o4_q | ovf32(fin[0]) | ovf32(fin[1]) | ovf32(fin[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= beat_i.valid;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    o3_q   <= beat_i.ovf;
    sum_q  <= sum_d;
    o4_q   <= o3_q;
    res_q  <= res_d;
  end

  assign valid_o  = v5_q;
  assign result_o = res_q;

endmodule

[test/rigid_point_transform_tb.sv]
// Self-checking testbench for the rigid point transform: random and directed points, all modes.
`timescale 1ns / 100ps

module rigid_point_transform_tb;
  import rpt_pkg::*;

  localparam fix_t FIX_HI = 32'sh7FFF_FFFF;
  localparam fix_t FIX_LO = 32'sh8000_0000;
  localparam fix_t COS45 = 32'sh2D41_3CCD;
  localparam longint MAT_GAIN = 2;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 10;

  typedef logic signed [67:0] wide_t;

  class pose_checker;
    fix_t quat_x, quat_y, quat_z, quat_w;
    fix_t shift[3];
    bit inverse;
    result_t expected_moves[$];
    int unsigned mismatches;

    function new();
      quat_x = '0;
      quat_y = '0;
      quat_z = '0;
      quat_w = QW_RESET;
      foreach (shift[i]) shift[i] = '0;
      inverse = 1'b0;
      mismatches = 0;
    endfunction

    function void load_reg(cfg_idx_e idx, logic [31:0] d);
      case (idx)
        CFG_QX: quat_x = d;
        CFG_QY: quat_y = d;
        CFG_QZ: quat_z = d;
        CFG_QW: quat_w = d;
        CFG_TX: shift[0] = d;
        CFG_TY: shift[1] = d;
        CFG_TZ: shift[2] = d;
        CFG_INV: inverse = d[0];
        default: ;
      endcase
    endfunction

    function longint q_mul(fix_t a, fix_t b);
      return (longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function wide_t clamp(wide_t v, inout bit hit);
      if (v > FIX_HI) begin
        hit = 1'b1;
        return wide_t'(FIX_HI);
      end
      if (v < FIX_LO) begin
        hit = 1'b1;
        return wide_t'(FIX_LO);
      end
      return v;
    endfunction

    // out-of-range coefficients clip silently
    function wide_t coef(longint s, bit diag);
      bit ignored;
      ignored = 1'b0;
      return clamp(wide_t'(MAT_GAIN * s + (diag ? (longint'(1) <<< FRAC_W) : 0)), ignored);
    endfunction

    function wide_t round_q30(wide_t a);
      return (a + (wide_t'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function result_t rigid_move(point_t p);
      longint wx, wy, wz, xx, xy, xz, yy, yz, zz;
      wide_t m[3][3];
      wide_t v[3];
      wide_t acc;
      fix_t o[3];
      bit ovf;
      result_t r;
      wx = q_mul(quat_w, quat_x);
      wy = q_mul(quat_w, quat_y);
      wz = q_mul(quat_w, quat_z);
      xx = q_mul(quat_x, quat_x);
      xy = q_mul(quat_x, quat_y);
      xz = q_mul(quat_x, quat_z);
      yy = q_mul(quat_y, quat_y);
      yz = q_mul(quat_y, quat_z);
      zz = q_mul(quat_z, quat_z);
      m[0][0] = coef(-(yy + zz), 1'b1);
      m[0][1] = coef(xy - wz, 1'b0);
      m[0][2] = coef(wy + xz, 1'b0);
      m[1][0] = coef(wz + xy, 1'b0);
      m[1][1] = coef(-(xx + zz), 1'b1);
      m[1][2] = coef(yz - wx, 1'b0);
      m[2][0] = coef(xz - wy, 1'b0);
      m[2][1] = coef(wx + yz, 1'b0);
      m[2][2] = coef(-(xx + yy), 1'b1);
      v[0] = wide_t'(p.point_x);
      v[1] = wide_t'(p.point_y);
      v[2] = wide_t'(p.point_z);
      ovf = 1'b0;
      if (inverse) begin
        for (int i = 0; i < 3; i++) v[i] = clamp(v[i] - wide_t'(shift[i]), ovf);
        for (int i = 0; i < 3; i++) begin
          acc = '0;
          for (int j = 0; j < 3; j++) acc += m[j][i] * v[j];
          o[i] = fix_t'(clamp(round_q30(acc), ovf));
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          acc = '0;
          for (int j = 0; j < 3; j++) acc += m[i][j] * v[j];
          o[i] = fix_t'(clamp(round_q30(acc) + wide_t'(shift[i]), ovf));
        end
      end
      r.out_x = o[0];
      r.out_y = o[1];
      r.out_z = o[2];
      r.overflow = ovf;
      return r;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("%0t: %s", $time, msg);
    endtask

    function void note_point(point_t p);
      expected_moves.push_back(rigid_move(p));
    endfunction

    task check_result(result_t r);
      result_t e;
      if (expected_moves.size() == 0) begin
        report($sformatf("unexpected result beat %h", r));
      end else begin
        e = expected_moves.pop_front();
        if (r.out_x !== e.out_x) report($sformatf("out_x got %h want %h", r.out_x, e.out_x));
        if (r.out_y !== e.out_y) report($sformatf("out_y got %h want %h", r.out_y, e.out_y));
        if (r.out_z !== e.out_z) report($sformatf("out_z got %h want %h", r.out_z, e.out_z));
        if (r.overflow !== e.overflow) begin
          report($sformatf("overflow got %b want %b", r.overflow, e.overflow));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  point_t point_i;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic result_valid_o;
  result_t result_o;

  pose_checker sb = new();
  bit steady = 1'b0;
  int unsigned cycles = 0;

  rigid_point_transform i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .point_i        (point_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.load_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (start_i && !busy_o) sb.note_point(point_i);
      if (result_valid_o) sb.check_result(result_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic fix_t pick_extreme();
    case ($urandom_range(4))
      0: return FIX_HI;
      1: return FIX_LO;
      2: return 32'sd0;
      3: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic fix_t rand_coord(int kind);
    case (kind)
      0: return fix_t'($urandom);
      1: return pick_extreme();
      default: return $signed($urandom) >>> $urandom_range(6, 24);
    endcase
  endfunction

  task automatic send_point(point_t p);
    bit ok;
    while (!steady && $urandom_range(99) < 32) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    point_i <= p;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk_i);
      ok = !busy_o;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_moves.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  task automatic set_transform(fix_t qx, fix_t qy, fix_t qz, fix_t qw,
                               fix_t tx, fix_t ty, fix_t tz, bit inv);
    drain();
    write_reg(CFG_QX, qx);
    write_reg(CFG_QY, qy);
    write_reg(CFG_QZ, qz);
    write_reg(CFG_QW, qw);
    write_reg(CFG_TX, tx);
    write_reg(CFG_TY, ty);
    write_reg(CFG_TZ, tz);
    // upper bits of the mode register are don't-care
    write_reg(CFG_INV, {31'($urandom), inv});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    fix_t rq[4];
    fix_t rt[3];
    real a[4];
    real norm;
    int pick;
    point_t pt;
    start_i <= 1'b0;
    point_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_QX;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity from reset
    send_point('{FIX_HI, FIX_LO, 32'sd0});
    send_point('{32'sd1, -32'sd1, 32'sh1234_5678});
    // quarter turn about z
    set_transform(0, 0, COS45, COS45, 0, 0, 0, 1'b0);
    send_point('{FIX_HI, FIX_HI, FIX_HI});
    send_point('{FIX_LO, FIX_LO, FIX_LO});
    send_point('{32'sh0001_0000, 32'sd0, 32'sd0});
    // inverse, difference saturates
    set_transform(0, 0, COS45, COS45, FIX_HI, FIX_LO, 32'sh0001_0000, 1'b1);
    send_point('{FIX_LO, FIX_HI, 32'sd0});
    send_point('{32'sd0, 32'sd0, 32'sd0});
    send_point('{FIX_HI, FIX_LO, 32'sd1});
    // forward, translation saturates
    set_transform(0, 0, 0, QW_RESET, FIX_HI, FIX_LO, 0, 1'b0);
    send_point('{32'sd1, -32'sd1, 32'sd0});
    send_point('{FIX_HI, FIX_LO, 32'sd5});
    // non-unit quaternions, coefficients clip for the large ones
    set_transform(FIX_HI, FIX_HI, FIX_HI, FIX_HI, 0, 0, 0, 1'b0);
    send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    send_point('{FIX_HI, FIX_LO, FIX_HI});
    set_transform(FIX_LO, FIX_LO, FIX_LO, FIX_LO, 0, 0, 0, 1'b1);
    send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    send_point('{FIX_HI, FIX_LO, FIX_HI});
    set_transform(0, 0, 0, 0, 0, 0, 0, 1'b0);
    send_point('{-32'sd1, FIX_HI, FIX_LO});
    // half-scale rotation, rounding ties
    set_transform(32'sh2000_0000, 0, 0, 32'sh2000_0000, 0, 0, 0, 1'b0);
    send_point('{32'sd1, -32'sd1, 32'sd3});
    send_point('{-32'sh0000_8001, 32'sh0000_8000, -32'sd3});

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        norm = 0.0;
        foreach (a[i]) begin
          a[i] = real'(int'($urandom_range(2000000)) - 1000000);
          norm += a[i] * a[i];
        end
        norm = $sqrt(norm);
        if (norm == 0.0) norm = 1.0;
        foreach (rq[i]) rq[i] = $rtoi(a[i] / norm * 1073741824.0);
      end else if (pick < 8) begin
        foreach (rq[i]) rq[i] = fix_t'($urandom);
      end else begin
        foreach (rq[i]) rq[i] = pick_extreme();
      end
      foreach (rt[i]) begin
        if ($urandom_range(3) == 0) rt[i] = fix_t'($urandom);
        else rt[i] = $signed($urandom) >>> $urandom_range(4, 16);
      end
      set_transform(rq[0], rq[1], rq[2], rq[3], rt[0], rt[1], rt[2], 1'($urandom_range(1)));
      steady = (ph == 3);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(9);
        pt.point_x = rand_coord(pick);
        pt.point_y = rand_coord(pick);
        pt.point_z = rand_coord(pick);
        send_point(pt);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
